// ===== rtl/core/binary_to_decimal_ascii_unit_assert.svh =====
// Assertion macros shared by the decimal text converter modules.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define B2DA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/b2da_pkg.sv =====
// Shared types and constants of the binary to decimal text converter.
`default_nettype none

package b2da_pkg;

  // Value split point and fixed-point reciprocal of 10000 (0.28 format).
  localparam logic [31:0] DEC_SPLIT   = 32'd100000;
  localparam logic [14:0] RECIP_1E4   = 15'((1 << 28) / 10000 + 1);
  localparam int          QUOT_W      = 16;
  localparam logic [31:0] DIV_TOP     = DEC_SPLIT << (QUOT_W - 1);
  localparam int          HALF_W      = 17;
  localparam int          FRAC_W      = 28;
  localparam logic [5:0]  ASCII_ZERO  = 6'd48;
  localparam logic [3:0]  HALF_IDX    = 4'd4;
  localparam logic [3:0]  LAST_IDX    = 4'd9;

  // Split unit sequencer.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL_HI,
    S_MUL_LO,
    S_HOLD
  } split_state_t;

  // Digit emitter sequencer.
  typedef enum logic [0:0] {
    E_IDLE,
    E_RUN
  } emit_state_t;

  // Scaled fractions of both five-digit halves.
  typedef struct packed {
    logic [31:0] t_hi;
    logic [31:0] t_lo;
  } frac_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_to_decimal_ascii_unit.sv =====
// Flow: an accepted value goes through 16 divide steps, 2 multiply steps and the hand-off
// to the digit emitter; each suppressed leading zero further delays its first digit.
// The one-bit-per-cycle divide by 100000 sets the value rate; the digit emitter (one digit
// per cycle while out_ready does not stall it) overlaps the next divide after the hand-off.
// Reset: synchronous active low rst_n empties both units and clears pad_digits to 0.
`default_nettype none

module binary_to_decimal_ascii_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_digit_char,
  output logic             out_is_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_pad_digits
);

  logic            pad_r;
  logic            frac_valid;
  logic            frac_ready;
  b2da_pkg::frac_t frac;

  // Configuration register, always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pad_r <= cfg_pad_digits;
    end
  end

  // Division and scaling of both halves.
  b2da_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .frac_valid (frac_valid),
    .frac_ready (frac_ready),
    .frac       (frac)
  );

  // Digit peeling and output register.
  b2da_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .pad            (pad_r),
    .frac_valid     (frac_valid),
    .frac_ready     (frac_ready),
    .frac           (frac),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_is_last    (out_is_last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/b2da_split.sv =====
// Split unit: divides the value by 100000 one quotient bit per cycle and scales both halves.
`default_nettype none
`include "binary_to_decimal_ascii_unit_assert.svh"

module b2da_split (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [31:0]    in_value,
  output logic                frac_valid,
  input  wire logic           frac_ready,
  output b2da_pkg::frac_t     frac
);

  b2da_pkg::split_state_t state_r, state_nxt;

  logic [31:0] rem_r;
  logic [31:0] div_r;
  logic [15:0] quot_r;
  logic [3:0]  cnt_r;
  logic [31:0] t_hi_r;
  logic [31:0] t_lo_r;

  logic                        sub_ok;
  logic [b2da_pkg::HALF_W-1:0] mul_h;
  logic [31:0]                 t_calc;

  // One restoring division step per cycle.
  assign sub_ok = (rem_r >= div_r);

  // Shared multiplier: quotient first, then remainder.
  assign mul_h  = (state_r == b2da_pkg::S_MUL_HI) ? {1'b0, quot_r} : rem_r[16:0];
  assign t_calc = 32'(mul_h) * 32'(b2da_pkg::RECIP_1E4) - 32'(mul_h[16:2]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      b2da_pkg::S_IDLE:   if (in_valid) state_nxt = b2da_pkg::S_DIV;
      b2da_pkg::S_DIV:    if (cnt_r == 4'd0) state_nxt = b2da_pkg::S_MUL_HI;
      b2da_pkg::S_MUL_HI: state_nxt = b2da_pkg::S_MUL_LO;
      b2da_pkg::S_MUL_LO: state_nxt = b2da_pkg::S_HOLD;
      b2da_pkg::S_HOLD:   if (frac_ready) state_nxt = b2da_pkg::S_IDLE;
      default:            state_nxt = b2da_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = (state_r == b2da_pkg::S_IDLE);
    frac_valid = (state_r == b2da_pkg::S_HOLD);
    frac.t_hi  = t_hi_r;
    frac.t_lo  = t_lo_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2da_pkg::S_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == b2da_pkg::S_IDLE) begin
        cnt_r <= 4'(b2da_pkg::QUOT_W - 1);
      end else if (state_r == b2da_pkg::S_DIV) begin
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      b2da_pkg::S_IDLE: begin
        rem_r <= in_value;
        div_r <= b2da_pkg::DIV_TOP;
      end
      b2da_pkg::S_DIV: begin
        if (sub_ok) rem_r <= rem_r - div_r;
        div_r  <= {1'b0, div_r[31:1]};
        quot_r <= {quot_r[14:0], sub_ok};
      end
      b2da_pkg::S_MUL_HI: t_hi_r <= t_calc;
      b2da_pkg::S_MUL_LO: t_lo_r <= t_calc;
      default: ;
    endcase
  end

  // The partial remainder never reaches twice the current divisor step.
  `B2DA_ASSERT_SAME(a_rem_bound, state_r == b2da_pkg::S_DIV,
    ({1'b0, rem_r} < {div_r, 1'b0}), "split: partial remainder out of range")
  // After the last step the remainder is a valid low half.
  `B2DA_ASSERT_SAME(a_rem_final, state_r == b2da_pkg::S_MUL_HI,
    rem_r < b2da_pkg::DEC_SPLIT, "split: remainder not below 100000")
  // An accepted value always starts the division.
  `B2DA_ASSERT_NEXT(a_start_div, in_valid && in_ready,
    state_r == b2da_pkg::S_DIV && cnt_r == 4'(b2da_pkg::QUOT_W - 1),
    "split: division did not start")

endmodule

`default_nettype wire

// ===== rtl/core/b2da_emit.sv =====
// Digit emitter: peels one decimal digit per cycle unless the output stalls, and drives the output register.
`default_nettype none
`include "binary_to_decimal_ascii_unit_assert.svh"

module b2da_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pad,
  input  wire logic           frac_valid,
  output logic                frac_ready,
  input  wire b2da_pkg::frac_t frac,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [5:0]          out_digit_char,
  output logic                out_is_last
);

  b2da_pkg::emit_state_t state_r, state_nxt;

  logic [31:0] cur_r;
  logic [31:0] lo_r;
  logic [3:0]  idx_r;
  logic        leading_r;
  logic        out_valid_r;
  logic [5:0]  out_char_r;
  logic        out_last_r;

  logic [3:0]  dig;
  logic        skip;
  logic        slot_free;
  logic        step;
  logic        emit;
  logic [31:0] cur_x10;

  // Digit selection and leading zero suppression.
  assign dig       = cur_r[31:28];
  assign skip      = !pad && leading_r && (dig == 4'd0) && (idx_r != b2da_pkg::LAST_IDX);
  assign slot_free = !out_valid_r || out_ready;
  assign step      = (state_r == b2da_pkg::E_RUN) && (skip || slot_free);
  assign emit      = step && !skip;

  // Fraction times ten as two shifted adds.
  assign cur_x10 = {1'b0, cur_r[b2da_pkg::FRAC_W-1:0], 3'b000}
                 + {3'b000, cur_r[b2da_pkg::FRAC_W-1:0], 1'b0};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      b2da_pkg::E_IDLE: if (frac_valid) state_nxt = b2da_pkg::E_RUN;
      b2da_pkg::E_RUN:  if (step && idx_r == b2da_pkg::LAST_IDX) state_nxt = b2da_pkg::E_IDLE;
      default:          state_nxt = b2da_pkg::E_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    frac_ready     = (state_r == b2da_pkg::E_IDLE);
    out_valid      = out_valid_r;
    out_digit_char = out_char_r;
    out_is_last    = out_last_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b2da_pkg::E_IDLE;
      idx_r       <= 4'd0;
      leading_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (frac_valid && frac_ready) begin
        idx_r     <= 4'd0;
        leading_r <= 1'b1;
      end else if (step) begin
        idx_r <= idx_r + 4'd1;
        if (!skip) leading_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (frac_valid && frac_ready) begin
      cur_r <= frac.t_hi;
      lo_r  <= frac.t_lo;
    end else if (step) begin
      cur_r <= (idx_r == b2da_pkg::HALF_IDX) ? lo_r : cur_x10;
    end
    if (emit) begin
      out_char_r <= b2da_pkg::ASCII_ZERO + {2'b00, dig};
      out_last_r <= (idx_r == b2da_pkg::LAST_IDX);
    end
  end

  // Every emitted character is a decimal digit.
  `B2DA_ASSERT_SAME(a_digit_range, out_valid_r,
    out_char_r >= 6'd48 && out_char_r <= 6'd57, "emit: character is not a digit")
  // A new transaction from the split unit restarts the digit count.
  `B2DA_ASSERT_NEXT(a_restart, frac_valid && frac_ready,
    state_r == b2da_pkg::E_RUN && idx_r == 4'd0 && leading_r,
    "emit: run did not restart")
  // Leading digits are dropped only when padding is off.
  `B2DA_ASSERT_SAME(a_skip_nopad, state_r == b2da_pkg::E_RUN && leading_r && idx_r != 4'd0,
    !pad, "emit: digit dropped while padding")

endmodule

`default_nettype wire
